FILE: hdl/brot_pkg.sv
// Package: shared widths, constants, types and helpers of the bilinear mask rotator.
package brot_pkg;

  // Field widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int VAL_W   = 17;
  localparam int GRID_W  = 8;
  localparam int ANG_W   = 18;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 18;

  // Layer store geometry
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  // Q16 fixed point
  localparam int Q16_ONE = 65536;

  // Datapath widths
  localparam int K_W    = 9;    // centred index in half-cell units
  localparam int PROD_W = K_W + ANG_W;
  localparam int POS_W  = 28;   // source position, Q16
  localparam int BASE_W = POS_W - 16;
  localparam int ACC_W  = 20;

  // Configuration register indices
  typedef enum logic [CIDX_W-1:0] {
    CFG_GRID_COLS = 2'd0,
    CFG_GRID_ROWS = 2'd1,
    CFG_COS_ANGLE = 2'd2,
    CFG_SIN_ANGLE = 2'd3
  } cfg_idx_t;

  // Input operation codes
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_SUM,
    ST_WGT,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Configuration register set
  typedef struct packed {
    logic [GRID_W-1:0]       grid_cols;
    logic [GRID_W-1:0]       grid_rows;
    logic signed [ANG_W-1:0] cos_angle;
    logic signed [ANG_W-1:0] sin_angle;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_wr;
    logic       capture;
    logic       map_en;
    logic       sum_en;
    logic       wgt_en;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       out_load;
  } cmd_t;

  // Saturate a grid size to the store dimension
  function automatic logic [GRID_W-1:0] sat_grid(input logic [GRID_W-1:0] n,
                                                  input int lim);
    logic [GRID_W-1:0] r;
    r = (int'(n) > lim) ? GRID_W'(lim) : n;
    return r;
  endfunction

endpackage

FILE: hdl/brot_item_if.sv
// Interface: input word channel (load or sample request).
interface brot_item_if;
  import brot_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [VAL_W-1:0]   cell_value;

  modport source(output valid, func, col, row, cell_value, input ready);
  modport sink(input valid, func, col, row, cell_value, output ready);
endinterface

FILE: hdl/brot_result_if.sv
// Interface: result word channel.
interface brot_result_if;
  import brot_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] rotated_value;

  modport source(output valid, rotated_value, input ready);
  modport sink(input valid, rotated_value, output ready);
endinterface

FILE: hdl/brot_cfg_if.sv
// Interface: configuration write channel.
interface brot_cfg_if;
  import brot_pkg::*;

  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/brot_cfg_regs.sv
// Configuration register file of the rotator.
module brot_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  brot_cfg_if.sink      cfg,
  output brot_pkg::cfg_t regs
);
  import brot_pkg::*;

  // Always take a write word
  assign cfg.ready = 1'b1;

  // Decode and store register writes; unknown indices drop
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.grid_cols <= GRID_W'(MAX_COLS);
      regs.grid_rows <= GRID_W'(MAX_ROWS);
      regs.cos_angle <= ANG_W'(Q16_ONE);
      regs.sin_angle <= '0;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_GRID_COLS: regs.grid_cols <= cfg.data[GRID_W-1:0];
        CFG_GRID_ROWS: regs.grid_rows <= cfg.data[GRID_W-1:0];
        CFG_COS_ANGLE: regs.cos_angle <= $signed(cfg.data[ANG_W-1:0]);
        CFG_SIN_ANGLE: regs.sin_angle <= $signed(cfg.data[ANG_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/brot_ctrl.sv
// Controller: sequences loads and the sample steps, and owns the result valid flag.
module brot_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_func,
  output logic           item_ready,
  output logic           res_valid,
  input  logic           res_ready,
  output brot_pkg::cmd_t cmd
);
  import brot_pkg::*;

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       res_free;
  logic       accept;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign res_free   = !res_valid || res_ready;

  // Next state and step counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept && (func_t'(item_func) == FUNC_SAMPLE)) state_next = ST_MAP;
      end
      ST_MAP:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_WGT;
      ST_WGT: begin
        state_next = ST_READ;
        cnt_next   = '0;
      end
      ST_READ: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_wr = accept && (func_t'(item_func) == FUNC_LOAD);
        cmd.capture = accept && (func_t'(item_func) == FUNC_SAMPLE);
      end
      ST_MAP: cmd.map_en = 1'b1;
      ST_SUM: cmd.sum_en = 1'b1;
      ST_WGT: cmd.wgt_en = 1'b1;
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt;
      end
      ST_DRAIN: ;
      ST_DONE: cmd.out_load = res_free;
      default: ;
    endcase
  end

  // State, counter and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/brot_dp.sv
// Datapath: layer store, inverse mapping, weights and four-tap blend.
module brot_dp (
  input  logic                      clk,
  input  brot_pkg::cfg_t            regs,
  input  brot_pkg::cmd_t            cmd,
  input  logic [brot_pkg::COL_W-1:0] item_col,
  input  logic [brot_pkg::ROW_W-1:0] item_row,
  input  logic [brot_pkg::VAL_W-1:0] item_value,
  output logic [brot_pkg::VAL_W-1:0] rotated_value
);
  import brot_pkg::*;

  // Layer store
  logic [VAL_W-1:0] mem [DEPTH];

  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [GRID_W-1:0]        nx, ny;
  logic signed [K_W-1:0]    ki, kj, offx, offy;
  logic signed [PROD_W-1:0] pic, pjs, pjc, pis;
  logic signed [POS_W-1:0]  sx, sy;
  logic signed [BASE_W-1:0] x0, y0;
  logic [15:0]              tx, ty;
  logic [VAL_W-1:0]         cx, cy, ux, uy;
  logic [2*VAL_W-1:0]       p00, p10, p01, p11;
  logic [VAL_W-1:0]         w [4];
  logic signed [BASE_W:0]   xs, ys;
  logic                     ok;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic [VAL_W-1:0]         rd_data;
  logic                     rd_ok, rd_vld;
  logic [1:0]               rd_idx;
  logic [VAL_W-1:0]         tap;
  logic [2*VAL_W-1:0]       tprod;
  logic [VAL_W:0]           term;
  logic                     term_vld;
  logic [ACC_W-1:0]         acc;

  assign nx = sat_grid(regs.grid_cols, MAX_COLS);
  assign ny = sat_grid(regs.grid_rows, MAX_ROWS);

  // Centred indices in half-cell units and centre offsets
  assign ki   = $signed({1'b0, col_r, 1'b1}) - $signed({1'b0, nx});
  assign kj   = $signed({1'b0, row_r, 1'b1}) - $signed({1'b0, ny});
  assign offx = $signed({1'b0, nx}) - K_W'(1);
  assign offy = $signed({1'b0, ny}) - K_W'(1);

  // Capture sample position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r <= item_col;
      row_r <= item_row;
    end
  end

  // Rotation products
  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      pic <= ki * regs.cos_angle;
      pjs <= kj * regs.sin_angle;
      pjc <= kj * regs.cos_angle;
      pis <= ki * regs.sin_angle;
    end
  end

  // Source position: halve products (floor) and add the centre offset
  always_comb begin
    sx = {{(POS_W-PROD_W+1){pic[PROD_W-1]}}, pic[PROD_W-1:1]}
       + {{(POS_W-PROD_W+1){pjs[PROD_W-1]}}, pjs[PROD_W-1:1]}
       + {{(POS_W-K_W-15){offx[K_W-1]}}, offx, 15'd0};
    sy = {{(POS_W-PROD_W+1){pjc[PROD_W-1]}}, pjc[PROD_W-1:1]}
       - {{(POS_W-PROD_W+1){pis[PROD_W-1]}}, pis[PROD_W-1:1]}
       + {{(POS_W-K_W-15){offy[K_W-1]}}, offy, 15'd0};
  end

  // Split into base cell and fraction
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      x0 <= sx[POS_W-1:16];
      y0 <= sy[POS_W-1:16];
      tx <= sx[15:0];
      ty <= sy[15:0];
    end
  end

  // Bilinear weights
  assign ux  = {1'b0, tx};
  assign uy  = {1'b0, ty};
  assign cx  = VAL_W'(Q16_ONE) - ux;
  assign cy  = VAL_W'(Q16_ONE) - uy;
  assign p00 = cx * cy;
  assign p10 = ux * cy;
  assign p01 = cx * uy;
  assign p11 = ux * uy;

  always_ff @(posedge clk) begin
    if (cmd.wgt_en) begin
      w[0] <= p00[VAL_W+15:16];
      w[1] <= p10[VAL_W+15:16];
      w[2] <= p01[VAL_W+15:16];
      w[3] <= p11[VAL_W+15:16];
    end
  end

  // Neighbour address and grid check
  always_comb begin
    xs = {x0[BASE_W-1], x0} + (BASE_W+1)'(cmd.rd_idx[0]);
    ys = {y0[BASE_W-1], y0} + (BASE_W+1)'(cmd.rd_idx[1]);
    ok = !xs[BASE_W] && (xs[BASE_W-1:0] < BASE_W'(nx))
      && !ys[BASE_W] && (ys[BASE_W-1:0] < BASE_W'(ny));
    rd_addr = {ys[ROW_W-1:0], xs[COL_W-1:0]};
    wr_addr = {item_row, item_col};
  end

  // Single-port layer store
  always_ff @(posedge clk) begin
    if (cmd.load_wr) mem[wr_addr] <= item_value;
    else if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  // Read pipeline tags
  always_ff @(posedge clk) begin
    rd_vld <= cmd.rd_en;
    rd_ok  <= ok;
    rd_idx <= cmd.rd_idx;
  end

  // Weighted tap
  assign tap   = rd_ok ? rd_data : '0;
  assign tprod = w[rd_idx] * tap;

  always_ff @(posedge clk) begin
    term_vld <= rd_vld;
    term     <= tprod[2*VAL_W-1:16];
  end

  // Accumulate taps; clear when weights are formed
  always_ff @(posedge clk) begin
    if (cmd.wgt_en) acc <= '0;
    else if (term_vld) acc <= acc + ACC_W'(term);
  end

  // Clamp into the result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rotated_value <= (acc > ACC_W'(Q16_ONE)) ? VAL_W'(Q16_ONE) : acc[VAL_W-1:0];
    end
  end

endmodule

FILE: hdl/bilinear_mask_rotator_core.sv
// Top level of the bilinear mask rotator: config registers, controller and datapath.
//
//   channel  dir  words carried
//   item     in   func, col, row, cell_value (load or sample request)
//   result   out  rotated_value, one per sample
//   cfg      in   index, data (register write)
//
// A load is written to the layer store as it is accepted. A sample occupies the block
// from acceptance until its result is loaded: map, sum, weights, four reads of the
// single-port layer store (one per cycle) and a drain of the multiply and accumulate stages.
// A waiting result holds in its output register; loads are taken meanwhile, and a
// following sample stalls only at its last step until that register frees.
// Reset (rst, synchronous) restores the registers; the layer store is undefined until loaded.
module bilinear_mask_rotator_core (
  input  logic       clk,
  input  logic       rst,
  brot_item_if.sink  item,
  brot_result_if.source result,
  brot_cfg_if.sink   cfg
);
  import brot_pkg::*;

  cfg_t regs;
  cmd_t cmd;

  brot_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  brot_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .cmd        (cmd)
  );

  brot_dp u_dp (
    .clk           (clk),
    .regs          (regs),
    .cmd           (cmd),
    .item_col      (item.col),
    .item_row      (item.row),
    .item_value    (item.cell_value),
    .rotated_value (result.rotated_value)
  );

endmodule
